### hdl/pgc_pkg.sv
`default_nettype none
package pgc_pkg;

    localparam int FACE_W = 16;
    localparam int POS_W = 16;
    localparam int TURN_W = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FACE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_ENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_EXIT = 2'd2;

    localparam logic [FACE_W-1:0] FACE_THRESHOLD_RST = 16'd19661;
    localparam logic [TURN_W-1:0] TURN_ENTER_RST = 15'd8192;
    localparam logic [TURN_W-1:0] TURN_EXIT_RST = 15'd4096;

    typedef enum logic [2:0] {
        ST_NONE = 3'd0,
        ST_FORWARD = 3'd1,
        ST_RIGHT = 3'd2,
        ST_LEFT = 3'd3,
        ST_BACKWARD = 3'd4,
        ST_SIT = 3'd5,
        ST_STOP = 3'd6,
        ST_HI = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CMD_BALANCE = 3'd0,
        CMD_CRAWL_FORWARD = 3'd1,
        CMD_BACK = 3'd2,
        CMD_WALK_LEFT = 3'd3,
        CMD_WALK_RIGHT = 3'd4,
        CMD_SIT = 3'd5,
        CMD_HI = 3'd6
    } command_t;

    typedef struct packed {
        logic [FACE_W-1:0] face_threshold;
        logic [TURN_W-1:0] turn_enter;
        logic [TURN_W-1:0] turn_exit;
    } thresholds_t;

    typedef struct packed {
        logic crouching;
        logic arm_forward;
        logic arm_spread;
        logic arm_raised;
        logic signed [POS_W-1:0] pos_x;
        logic [FACE_W-1:0] face_score;
    } frame_t;

    function automatic command_t command_of(input status_t s);
        command_t c;
        case (s)
            ST_FORWARD: c = CMD_CRAWL_FORWARD;
            ST_RIGHT: c = CMD_WALK_RIGHT;
            ST_LEFT: c = CMD_WALK_LEFT;
            ST_BACKWARD: c = CMD_BACK;
            ST_SIT: c = CMD_SIT;
            ST_HI: c = CMD_HI;
            default: c = CMD_BALANCE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/pgc_pick.sv
`default_nettype none
module pgc_pick (
    input  wire pgc_pkg::frame_t      frame,
    input  wire pgc_pkg::thresholds_t thr,
    input  wire pgc_pkg::status_t     current_status,
    output pgc_pkg::status_t          candidate
);

    logic signed [pgc_pkg::POS_W:0] x;
    logic signed [pgc_pkg::POS_W:0] enter;
    logic signed [pgc_pkg::POS_W:0] leave;
    logic present;
    logic stop_gesture;
    pgc_pkg::status_t s;

    assign x = {frame.pos_x[pgc_pkg::POS_W-1], frame.pos_x};
    assign enter = {2'b00, thr.turn_enter};
    assign leave = {2'b00, thr.turn_exit};
    assign present = frame.face_score >= thr.face_threshold;
    assign stop_gesture = frame.arm_forward | frame.crouching;

    always_comb begin
        s = current_status;
        case (current_status) inside
            pgc_pkg::ST_NONE, pgc_pkg::ST_FORWARD: begin
                s = present ? pgc_pkg::ST_FORWARD : pgc_pkg::ST_NONE;
                if (x > enter) s = pgc_pkg::ST_RIGHT;
                if (x < -enter) s = pgc_pkg::ST_LEFT;
                if (frame.arm_raised) s = pgc_pkg::ST_BACKWARD;
                if (frame.arm_spread) s = pgc_pkg::ST_SIT;
                if (stop_gesture) s = pgc_pkg::ST_STOP;
            end
            pgc_pkg::ST_RIGHT, pgc_pkg::ST_LEFT: begin
                if ((-leave < x) && (x < leave)) s = pgc_pkg::ST_NONE;
                if (frame.arm_raised) s = pgc_pkg::ST_BACKWARD;
                if (stop_gesture) s = pgc_pkg::ST_STOP;
            end
            pgc_pkg::ST_BACKWARD: begin
                if (!frame.arm_raised) s = pgc_pkg::ST_NONE;
            end
            pgc_pkg::ST_SIT: begin
                if (!frame.arm_spread) s = pgc_pkg::ST_NONE;
            end
            default: begin
                if (frame.crouching) begin
                    s = frame.arm_forward ? pgc_pkg::ST_HI : pgc_pkg::ST_STOP;
                end else if (!frame.arm_forward) begin
                    s = pgc_pkg::ST_NONE;
                end
            end
        endcase
    end

    assign candidate = present ? s : pgc_pkg::ST_NONE;

endmodule
`default_nettype wire

### hdl/pose_gesture_command_fsm_unit.sv
`default_nettype none
// Channel   Direction  Payload
// s_        in         tdata: face_score, pos_x, arm_raised, arm_spread, arm_forward,
//                      crouching
// m_        out        tdata: command, status
// cfg_      in         cfg_index, cfg_data: threshold register writes
//
// An item is taken into an input register and decided there once the output can take
// it: the candidate, run filter and commit update state and load the result register.
// One item per cycle is sustained while m_tready holds; m_tvalid rises only on commit.
// A stalled result holds the input register, and with it s_tready, whether or not
// the waiting item gives a result.
// Reset is synchronous on aresetn low and restores thresholds and empty history;
// s_tready and cfg_ready stay low while it is held.
module pose_gesture_command_fsm_unit #(
    parameter int FILTER_DEPTH = 4
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // face_score[15:0], pos_x[31:16], arm_raised[32], arm_spread[33],
    // arm_forward[34], crouching[35], zero[39:36]
    input  wire  [pgc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // command[2:0], status[5:3], zero[7:6]
    output logic [pgc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [pgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [pgc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = $clog2(FILTER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH = CW'(FILTER_DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);

    pgc_pkg::thresholds_t thr_reg;
    pgc_pkg::frame_t frame_reg;
    logic in_valid_reg;
    pgc_pkg::status_t status_reg;
    pgc_pkg::status_t last_reg;
    logic [CW-1:0] run_reg;
    logic [CW-1:0] fill_reg;
    logic out_valid_reg;
    pgc_pkg::command_t out_cmd_reg;
    pgc_pkg::status_t out_status_reg;

    pgc_pkg::status_t candidate;
    logic [CW-1:0] run_next;
    logic [CW-1:0] fill_next;
    logic commit;
    logic advance;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.face_threshold <= pgc_pkg::FACE_THRESHOLD_RST;
            thr_reg.turn_enter <= pgc_pkg::TURN_ENTER_RST;
            thr_reg.turn_exit <= pgc_pkg::TURN_EXIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                pgc_pkg::REG_FACE_THRESHOLD: thr_reg.face_threshold <= cfg_data;
                pgc_pkg::REG_TURN_ENTER: thr_reg.turn_enter <= cfg_data[pgc_pkg::TURN_W-1:0];
                pgc_pkg::REG_TURN_EXIT: thr_reg.turn_exit <= cfg_data[pgc_pkg::TURN_W-1:0];
                default: ;
            endcase
        end
    end

    pgc_pick u_pick (
        .frame          (frame_reg),
        .thr            (thr_reg),
        .current_status (status_reg),
        .candidate      (candidate)
    );

    always_comb begin
        if ((fill_reg != '0) && (candidate == last_reg)) begin
            run_next = (run_reg < DEPTH) ? run_reg + ONE : run_reg;
        end else begin
            run_next = ONE;
        end
        fill_next = (fill_reg < DEPTH) ? fill_reg + ONE : fill_reg;
        commit = run_next >= fill_next;
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            frame_reg <= s_tdata[$bits(pgc_pkg::frame_t)-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= pgc_pkg::ST_NONE;
            last_reg <= pgc_pkg::ST_NONE;
            run_reg <= '0;
            fill_reg <= '0;
        end else if (advance) begin
            run_reg <= run_next;
            fill_reg <= fill_next;
            last_reg <= candidate;
            if (commit) begin
                status_reg <= candidate;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= commit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && commit) begin
            out_cmd_reg <= pgc_pkg::command_of(candidate);
            out_status_reg <= candidate;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_status_reg, out_cmd_reg};

endmodule
`default_nettype wire
